// File: rtl/core/cdf_pkg.sv
// ----------------------------------------------------------------------------
// cdf_pkg
// Shared types and constants of the checksummed frame deframer: reset
// values, register indexes, parser states and controller/datapath links.
// ----------------------------------------------------------------------------
package cdf_pkg;

    localparam int BYTE_W          = 8;
    localparam int INDEX_W         = 6;
    localparam int MAX_PAYLOAD_DEF = 64;

    localparam logic [BYTE_W-1:0] FIRST_HDR_RST  = 8'hAA;
    localparam logic [BYTE_W-1:0] SECOND_HDR_RST = 8'h55;

    // configuration register indexes
    localparam logic CFG_FIRST_HDR  = 1'b0;
    localparam logic CFG_SECOND_HDR = 1'b1;

    typedef enum logic [3:0] {
        ST_HUNT1,
        ST_HUNT2,
        ST_LEN,
        ST_DATA,
        ST_CKA,
        ST_CKB,
        ST_RD,
        ST_LD,
        ST_WAIT
    } t_state;

    typedef struct packed {
        logic store;
        logic len_load;
        logic cka_load;
        logic k_clear;
        logic k_advance;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic hdr1_match;
        logic hdr2_match;
        logic len_ok;
        logic data_room;
        logic data_done;
        logic check_ok;
        logic out_taken;
        logic out_last;
    } t_sts;

endpackage

// File: rtl/core/checksummed_frame_deframer_unit.sv
// ----------------------------------------------------------------------------
// checksummed_frame_deframer_unit
// Parsing takes one received byte per cycle while not draining; a byte causes
// no result except the second check byte of a good frame, after which each
// payload byte, the first included, is shown through a buffer read and an
// output load, the next read starting only once the previous byte is taken;
// input stalls during the drain. Synchronous active-low reset: parser hunts
// the first header, headers 0xAA/0x55.
// ----------------------------------------------------------------------------
module checksummed_frame_deframer_unit #(
    parameter int MAX_PAYLOAD = cdf_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [cdf_pkg::BYTE_W-1:0]    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [cdf_pkg::BYTE_W-1:0]    i_rx_byte,
    input  logic                          i_message_end,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [cdf_pkg::BYTE_W-1:0]    o_payload_byte,
    output logic [cdf_pkg::INDEX_W-1:0]   o_payload_index,
    output logic                          o_payload_last
);
    import cdf_pkg::*;

    t_cmd cmd;
    t_sts sts;

    cdf_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_message_end (i_message_end),
        .o_stall       (o_stall),
        .i_sts         (sts),
        .o_cmd         (cmd)
    );

    cdf_datapath #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_rx_byte       (i_rx_byte),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_payload_byte  (o_payload_byte),
        .o_payload_index (o_payload_index),
        .o_payload_last  (o_payload_last)
    );

endmodule

// File: rtl/core/cdf_ram.sv
// ----------------------------------------------------------------------------
// cdf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/cdf_datapath.sv
// ----------------------------------------------------------------------------
// cdf_datapath
// Header registers, length and count, running sum, check compare, payload
// buffer and the output register of the deframer.
// ----------------------------------------------------------------------------
module cdf_datapath #(
    parameter int MAX_PAYLOAD = cdf_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [cdf_pkg::BYTE_W-1:0]    i_cfg_data,
    input  logic [cdf_pkg::BYTE_W-1:0]    i_rx_byte,
    input  cdf_pkg::t_cmd                 i_cmd,
    output cdf_pkg::t_sts                 o_sts,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic [cdf_pkg::BYTE_W-1:0]    o_payload_byte,
    output logic [cdf_pkg::INDEX_W-1:0]   o_payload_index,
    output logic                          o_payload_last
);
    import cdf_pkg::*;

    localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [BYTE_W-1:0]  r_first_hdr;
    logic [BYTE_W-1:0]  r_second_hdr;
    logic [LEN_W-1:0]   r_len;
    logic [LEN_W-1:0]   r_taken;
    logic [LEN_W-1:0]   r_k;
    logic [BYTE_W-1:0]  r_sum;
    logic [BYTE_W-1:0]  r_cka;
    logic               r_out_valid;
    logic [BYTE_W-1:0]  r_out_byte;
    logic [INDEX_W-1:0] r_out_index;
    logic               r_out_last;

    logic [BYTE_W-1:0]  ram_rdata;
    logic [BYTE_W-1:0]  check_b;
    logic [LEN_W:0]     taken_inc;
    logic [LEN_W:0]     k_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_hdr  <= FIRST_HDR_RST;
            r_second_hdr <= SECOND_HDR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FIRST_HDR:  r_first_hdr  <= i_cfg_data;
                CFG_SECOND_HDR: r_second_hdr <= i_cfg_data;
                default:        r_first_hdr  <= r_first_hdr;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.len_load) begin
            r_len   <= i_rx_byte[LEN_W-1:0];
            r_taken <= '0;
            r_sum   <= '0;
        end else if (i_cmd.store) begin
            r_taken <= r_taken + LEN_W'(1);
            r_sum   <= r_sum + i_rx_byte;
        end
        if (i_cmd.cka_load) begin
            r_cka <= i_rx_byte;
        end
        if (i_cmd.k_clear) begin
            r_k <= '0;
        end else if (i_cmd.k_advance) begin
            r_k <= r_k + LEN_W'(1);
        end
    end

    cdf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_PAYLOAD)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (i_cmd.store),
        .i_waddr (r_taken[ADDR_W-1:0]),
        .i_wdata (i_rx_byte),
        .i_raddr (r_k[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign k_inc = {1'b0, r_k} + (LEN_W+1)'(1);

    // output register: loaded from the buffer, freed when the request is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_byte  <= ram_rdata;
            r_out_index <= INDEX_W'(r_k);
            r_out_last  <= (k_inc == {1'b0, r_len});
        end
    end

    assign check_b   = {r_sum[BYTE_W-2:0], 1'b0};
    assign taken_inc = {1'b0, r_taken} + (LEN_W+1)'(1);

    always_comb begin
        o_sts.hdr1_match = (i_rx_byte == r_first_hdr);
        o_sts.hdr2_match = (i_rx_byte == r_second_hdr);
        o_sts.len_ok     = ({1'b0, i_rx_byte} <= (BYTE_W+1)'(MAX_PAYLOAD));
        o_sts.data_room  = (r_taken < r_len);
        o_sts.data_done  = (taken_inc == {1'b0, r_len});
        o_sts.check_ok   = (r_cka == r_sum) && (i_rx_byte == check_b);
        o_sts.out_taken  = r_out_valid && !i_stall;
        o_sts.out_last   = r_out_last;
    end

    assign o_valid         = r_out_valid;
    assign o_payload_byte  = r_out_byte;
    assign o_payload_index = r_out_index;
    assign o_payload_last  = r_out_last;

endmodule

// File: rtl/core/cdf_ctrl.sv
// ----------------------------------------------------------------------------
// cdf_ctrl
// Parser and drain sequencer: walks the frame fields on accepted bytes and
// steps the buffer read-out of a frame whose checks matched.
// ----------------------------------------------------------------------------
module cdf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_message_end,
    output logic          o_stall,
    input  cdf_pkg::t_sts i_sts,
    output cdf_pkg::t_cmd o_cmd
);
    import cdf_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   draining;
    logic   accept;

    assign draining = (r_state == ST_RD) || (r_state == ST_LD) || (r_state == ST_WAIT);
    assign o_stall  = draining;
    assign accept   = i_valid && !draining;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT1;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_HUNT1: begin
                if (accept && i_sts.hdr1_match) n_state = ST_HUNT2;
            end
            ST_HUNT2: begin
                if (accept && i_sts.hdr2_match) n_state = ST_LEN;
            end
            ST_LEN: begin
                if (accept) begin
                    o_cmd.len_load = 1'b1;
                    n_state = i_sts.len_ok ? ST_DATA : ST_HUNT1;
                end
            end
            ST_DATA: begin
                // a zero length never leaves here until a message end
                if (accept && i_sts.data_room) begin
                    o_cmd.store = 1'b1;
                    if (i_sts.data_done) n_state = ST_CKA;
                end
            end
            ST_CKA: begin
                if (accept) begin
                    o_cmd.cka_load = 1'b1;
                    n_state = ST_CKB;
                end
            end
            ST_CKB: begin
                if (accept) begin
                    if (i_sts.check_ok) begin
                        o_cmd.k_clear = 1'b1;
                        n_state = ST_RD;
                    end else begin
                        n_state = ST_HUNT1;
                    end
                end
            end
            ST_RD: begin
                n_state = ST_LD;
            end
            ST_LD: begin
                o_cmd.out_load = 1'b1;
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                if (i_sts.out_taken) begin
                    if (i_sts.out_last) begin
                        n_state = ST_HUNT1;
                    end else begin
                        o_cmd.k_advance = 1'b1;
                        n_state = ST_RD;
                    end
                end
            end
            default: begin
                n_state = ST_HUNT1;
            end
        endcase
        // message end restarts the parser, but a good frame still drains first
        if (accept && i_message_end && !(r_state == ST_CKB && i_sts.check_ok)) begin
            n_state = ST_HUNT1;
        end
    end

endmodule

// File: tb/tb_checksummed_frame_deframer_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_checksummed_frame_deframer_unit
// Self-checking bench for the frame deframer. A byte stream of directed and
// random frames (good, corrupted, cut short, zero or over-long length, noise)
// is pushed through the parser under several header settings. A scoreboard
// class tracks the parser and predicts every emitted payload byte; the output
// side is checked in order, field by field, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_checksummed_frame_deframer_unit;

    import cdf_pkg::*;

    localparam int MAX_LEN     = MAX_PAYLOAD_DEF;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [BYTE_W-1:0]  data;
        logic [INDEX_W-1:0] pos;
        logic               last;
    } t_payload;

    typedef enum int {
        FLAW_NONE,
        FLAW_CKA,
        FLAW_CKB,
        FLAW_CUT
    } t_frame_flaw;

    // ------------------------------------------------------------------------
    // Tracks the parser and holds the payload bytes still owed by the block.
    // ------------------------------------------------------------------------
    class deframer_scoreboard;
        logic [BYTE_W-1:0] hdr1;
        logic [BYTE_W-1:0] hdr2;
        t_state            parse_phase;
        logic [6:0]        frame_len;
        logic [6:0]        taken;
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] rx_cka;
        logic [BYTE_W-1:0] store [MAX_LEN];
        t_payload          pending [$];
        int                mismatches;

        function new();
            hdr1       = FIRST_HDR_RST;
            hdr2       = SECOND_HDR_RST;
            mismatches = 0;
            clear_parser();
        endfunction

        function void clear_parser();
            parse_phase = ST_HUNT1;
            frame_len   = '0;
            taken       = '0;
            sum         = '0;
            rx_cka      = '0;
        endfunction

        function void set_header(logic idx, logic [BYTE_W-1:0] v);
            if (idx == CFG_FIRST_HDR) begin
                hdr1 = v;
            end else begin
                hdr2 = v;
            end
        endfunction

        function void note_byte(logic [BYTE_W-1:0] b, logic e);
            logic [BYTE_W-1:0] chk_b;
            t_payload          item;
            case (parse_phase)
                ST_HUNT1: begin
                    if (b == hdr1) parse_phase = ST_HUNT2;
                end
                ST_HUNT2: begin
                    if (b == hdr2) parse_phase = ST_LEN;
                end
                ST_LEN: begin
                    sum   = '0;
                    taken = '0;
                    if (b > MAX_LEN) begin
                        frame_len   = '0;
                        parse_phase = ST_HUNT1;
                    end else begin
                        frame_len   = b[6:0];
                        parse_phase = ST_DATA;
                    end
                end
                ST_DATA: begin
                    // zero length never leaves this state until message end
                    if (taken < frame_len && taken < MAX_LEN) begin
                        store[taken[5:0]] = b;
                        sum               = sum + b;
                        taken             = taken + 1'b1;
                        if (taken == frame_len) parse_phase = ST_CKA;
                    end
                end
                ST_CKA: begin
                    rx_cka      = b;
                    parse_phase = ST_CKB;
                end
                ST_CKB: begin
                    chk_b = sum + sum;
                    if (rx_cka == sum && b == chk_b) begin
                        for (int k = 0; k < frame_len && k < MAX_LEN; k++) begin
                            item.data = store[k[5:0]];
                            item.pos  = k[INDEX_W-1:0];
                            item.last = (k + 1 == frame_len);
                            pending.push_back(item);
                        end
                    end
                    clear_parser();
                end
                default: begin
                    clear_parser();
                end
            endcase
            if (e) clear_parser();
        endfunction

        function void check_payload(logic [BYTE_W-1:0] b, logic [INDEX_W-1:0] idx,
                                    logic last);
            t_payload exp_item;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected payload: byte %02h index %0d last %0d",
                             b, idx, last);
                return;
            end
            exp_item = pending.pop_front();
            if (exp_item.data !== b || exp_item.pos !== idx ||
                exp_item.last !== last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"payload mismatch: expected byte %02h index %0d last %0d,",
                              " got byte %02h index %0d last %0d"},
                             exp_item.data, exp_item.pos, exp_item.last, b, idx, last);
            end
        endfunction
    endclass

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_we      = 1'b0;
    logic                i_cfg_idx     = 1'b0;
    logic [BYTE_W-1:0]   i_cfg_data    = '0;
    logic                i_valid       = 1'b0;
    logic                o_stall;
    logic [BYTE_W-1:0]   i_rx_byte     = '0;
    logic                i_message_end = 1'b0;
    logic                o_valid;
    logic                i_stall       = 1'b0;
    logic [BYTE_W-1:0]   o_payload_byte;
    logic [INDEX_W-1:0]  o_payload_index;
    logic                o_payload_last;

    deframer_scoreboard  sb = new();
    bit                  steady     = 1'b0;
    int                  bytes_sent = 0;
    int                  cycles     = 0;

    checksummed_frame_deframer_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_rx_byte       (i_rx_byte),
        .i_message_end   (i_message_end),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_payload_byte  (o_payload_byte),
        .o_payload_index (o_payload_index),
        .o_payload_last  (o_payload_last)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // output side: check accepted results, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && !i_stall)
            sb.check_payload(o_payload_byte, o_payload_index, o_payload_last);
        i_stall <= !steady && ($urandom_range(99) < 27);
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic e);
        // idle at random before driving the byte, unless steady
        while (!steady && $urandom_range(99) < 27) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_rx_byte     <= b;
        i_message_end <= e;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        sb.note_byte(b, e);
        bytes_sent++;
    endtask

    function automatic logic [BYTE_W-1:0] other_than(logic [BYTE_W-1:0] x);
        logic [BYTE_W-1:0] v;
        do v = 8'($urandom); while (v == x);
        return v;
    endfunction

    task automatic send_frame(input int len, input t_frame_flaw flaw,
                              input bit end_last);
        logic [BYTE_W-1:0] frame_q [$];
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] v;
        int                n;
        bit                ending;
        sum    = '0;
        ending = end_last;
        n = $urandom_range(2);
        repeat (n) frame_q.push_back(other_than(sb.hdr1));
        frame_q.push_back(sb.hdr1);
        n = $urandom_range(2);
        repeat (n) frame_q.push_back(other_than(sb.hdr2));
        frame_q.push_back(sb.hdr2);
        frame_q.push_back(len[BYTE_W-1:0]);
        if (len <= MAX_LEN) begin
            for (int i = 0; i < len; i++) begin
                v = 8'($urandom);
                sum = sum + v;
                frame_q.push_back(v);
            end
        end
        v = (flaw == FLAW_CKA) ? 8'($urandom_range(1, 255)) : 8'h00;
        frame_q.push_back(sum ^ v);
        v = (flaw == FLAW_CKB) ? 8'($urandom_range(1, 255)) : 8'h00;
        frame_q.push_back((sum + sum) ^ v);
        if (flaw == FLAW_CUT) begin
            // keep a random leading part, possibly all, and end the message on it
            n = $urandom_range(frame_q.size() - 1);
            frame_q = frame_q[0:n];
            ending  = 1'b1;
        end
        for (int i = 0; i < frame_q.size(); i++)
            send_byte(frame_q[i], ending && (i == frame_q.size() - 1));
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_headers(input logic [BYTE_W-1:0] h1,
                                 input logic [BYTE_W-1:0] h2);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_FIRST_HDR;
        i_cfg_data <= h1;
        @(posedge i_clk);
        sb.set_header(CFG_FIRST_HDR, h1);
        i_cfg_idx  <= CFG_SECOND_HDR;
        i_cfg_data <= h2;
        @(posedge i_clk);
        sb.set_header(CFG_SECOND_HDR, h2);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        logic [8:0]        directed_q [$];
        logic [BYTE_W-1:0] h1_tab [5];
        logic [BYTE_W-1:0] h2_tab [5];
        int                target;
        int                r;
        int                len;
        int                n;
        bit                big_pending;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // {message_end, byte} under the reset headers
        directed_q = '{
            9'h0AA, 9'h055, 9'h001, 9'h0FF, 9'h0FF, 9'h0FE,          // one-byte good frame
            9'h0AA, 9'h055, 9'h000, 9'h012, 9'h134,                  // zero length until end
            9'h0AA, 9'h055, 9'h041, 9'h0FF,                          // length over the buffer
            9'h0AA, 9'h055, 9'h002, 9'h000, 9'h080, 9'h080, 9'h001,  // bad check B
            9'h0AA, 9'h155                                           // end inside a header
        };
        foreach (directed_q[i])
            send_byte(directed_q[i][7:0], directed_q[i][8]);
        settle();

        h1_tab = '{8'h00, 8'hFF, 8'h00, 8'h5A, 8'hAA};
        h2_tab = '{8'hFF, 8'h00, 8'h00, 8'h5A, 8'h55};
        h1_tab[2] = 8'($urandom);
        h2_tab[2] = 8'($urandom);
        big_pending = 1'b1;
        target = bytes_sent;

        for (int ph = 0; ph < 5; ph++) begin
            write_headers(h1_tab[ph], h2_tab[ph]);
            steady = (ph == 2);
            target += 56;
            while (bytes_sent < target) begin
                r = $urandom_range(99);
                len = ($urandom_range(9) == 0) ? $urandom_range(9, 63)
                                               : $urandom_range(1, 8);
                if (big_pending) begin
                    big_pending = 1'b0;
                    send_frame(MAX_LEN, FLAW_NONE, 1'b0);
                end else if (r < 60) begin
                    send_frame(len, FLAW_NONE, $urandom_range(4) == 0);
                end else if (r < 65) begin
                    send_frame(len, FLAW_CKA, 1'b0);
                end else if (r < 70) begin
                    send_frame(len, FLAW_CKB, 1'b0);
                end else if (r < 75) begin
                    send_frame(len, FLAW_CUT, 1'b1);
                end else if (r < 80) begin
                    send_frame(0, FLAW_NONE, 1'b1);
                end else if (r < 85) begin
                    send_frame($urandom_range(MAX_LEN + 1, 255), FLAW_NONE, 1'b0);
                end else begin
                    n = $urandom_range(1, 6);
                    repeat (n) send_byte(8'($urandom), $urandom_range(9) == 0);
                end
            end
            settle();
        end
        steady = 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/cdf_pkg.sv
rtl/core/cdf_ram.sv
rtl/core/cdf_datapath.sv
rtl/core/cdf_ctrl.sv
rtl/core/checksummed_frame_deframer_unit.sv
tb/tb_checksummed_frame_deframer_unit.sv
